// ===== src/wseek_pkg.sv =====
package wseek_pkg;

	// Item kind carried in the action field of an input word.
	localparam logic ACT_ADD  = 1'b0;
	localparam logic ACT_STEP = 1'b1;

	// Unit step decision on one axis.
	typedef struct packed {
		logic inc;
		logic dec;
	} step_t;

endpackage

// ===== src/wseek_item_if.sv =====
interface wseek_item_if #(
	parameter int COORD_BITS = 12
);
	logic                  valid;
	logic                  ready;
	logic                  action;
	logic [COORD_BITS-1:0] wp_x;
	logic [COORD_BITS-1:0] wp_y;
	logic [COORD_BITS-1:0] wp_radius;
	logic [COORD_BITS-1:0] pos_x;
	logic [COORD_BITS-1:0] pos_y;

	modport source (
		output valid, action, wp_x, wp_y, wp_radius, pos_x, pos_y,
		input  ready
	);
	modport sink (
		input  valid, action, wp_x, wp_y, wp_radius, pos_x, pos_y,
		output ready
	);
endinterface

// ===== src/wseek_result_if.sv =====
interface wseek_result_if #(
	parameter int COORD_BITS = 12
);
	logic                  valid;
	logic                  ready;
	logic                  has_destination;
	logic [COORD_BITS-1:0] desired_x;
	logic [COORD_BITS-1:0] desired_y;
	logic                  overflow;

	modport source (
		output valid, has_destination, desired_x, desired_y, overflow,
		input  ready
	);
	modport sink (
		input  valid, has_destination, desired_x, desired_y, overflow,
		output ready
	);
endinterface

// ===== src/waypoint_seek_step_unit.sv =====
// A word accepted on item is registered in the input stage, then in the result stage, before it shows on result.
// Throughput: one word per cycle unless result stalls; the destination compare, the pop from the
//   waypoint queue and both unit steps all settle between the input stage and the result stage.
// Stalls on result back up through the result stage and then the input stage.
// Reset (arst_n low): queue empty, no destination, desired position zero, both stages empty.
//   Queue storage itself is not reset; an entry is only read after it has been written.
module waypoint_seek_step_unit
	import wseek_pkg::*;
#(
	parameter int WAYPOINTS  = 16,
	parameter int COORD_BITS = 12
) (
	input  logic            clk,
	input  logic            arst_n,
	wseek_item_if.sink      item,
	wseek_result_if.source  result
);

	localparam int C   = COORD_BITS;
	localparam int EW  = 3 * C;                    // packed entry: r | y | x
	localparam int CW  = $clog2(WAYPOINTS + 1);    // fill count holds 0..WAYPOINTS
	localparam int SQW = 2 * C;                    // square of a C-bit magnitude
	localparam logic [C-1:0]  CMAX  = {C{1'b1}};
	localparam logic [CW-1:0] CFULL = CW'(WAYPOINTS);

	// ------------------------------------------------------------------
	// Input stage
	// ------------------------------------------------------------------
	logic         valid_s1;
	logic         action_s1;
	logic [C-1:0] wp_x_s1, wp_y_s1, wp_r_s1;
	logic [C-1:0] pos_x_s1, pos_y_s1;

	logic valid_s2;
	logic adv_s2;

	assign adv_s2     = valid_s1 && (!valid_s2 || result.ready);
	assign item.ready = !valid_s1 || adv_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			action_s1 <= item.action;
			wp_x_s1   <= item.wp_x;
			wp_y_s1   <= item.wp_y;
			wp_r_s1   <= item.wp_radius;
			pos_x_s1  <= item.pos_x;
			pos_y_s1  <= item.pos_y;
		end
	end

	// ------------------------------------------------------------------
	// Agent state
	// ------------------------------------------------------------------
	logic [CW-1:0] count_q;
	logic [EW-1:0] dest_q;
	logic          dest_valid_q;
	logic [C-1:0]  held_x_q, held_y_q;

	// Waypoint queue as a shift line: the front always sits in entry 0.
	logic [EW-1:0] fifo_q [WAYPOINTS];
	logic [EW-1:0] front;
	assign front = fifo_q[0];

	// ------------------------------------------------------------------
	// Distance and unit-step math, for the current destination and for
	// the queue front in parallel, so no square depends on another.
	// ------------------------------------------------------------------
	function automatic logic [C-1:0] abs_diff(input logic [C-1:0] a, input logic [C-1:0] b);
		abs_diff = (a >= b) ? (a - b) : (b - a);
	endfunction

	function automatic step_t unit_step(
		input logic [SQW-1:0] sq_d, input logic [SQW-1:0] sq_e,
		input logic [C-1:0] tgt, input logic [C-1:0] pos
	);
		logic [SQW+1:0] three_d;
		step_t          s;
		three_d = {2'b00, sq_d} + {1'b0, sq_d, 1'b0};
		s.inc   = 1'b0;
		s.dec   = 1'b0;
		if (three_d >= {2'b00, sq_e}) begin
			s.inc = tgt > pos;
			s.dec = tgt < pos;
		end
		unit_step = s;
	endfunction

	function automatic logic [C-1:0] apply_step(input logic [C-1:0] pos, input step_t s);
		apply_step = pos;
		if (s.inc && pos != CMAX)
			apply_step = pos + 1'b1;
		else if (s.dec && pos != '0)
			apply_step = pos - 1'b1;
	endfunction

	logic [C-1:0]   dest_x, dest_y, dest_r, front_x, front_y;
	logic [C-1:0]   adx_d, ady_d, adx_f, ady_f;
	logic [SQW-1:0] sqx_d, sqy_d, sqx_f, sqy_f, sq_r;
	logic [SQW:0]   dist_d;
	logic           reached, take, is_step;
	step_t          stx_d, sty_d, stx_f, sty_f;

	assign dest_x  = dest_q[C-1:0];
	assign dest_y  = dest_q[2*C-1:C];
	assign dest_r  = dest_q[3*C-1:2*C];
	assign front_x = front[C-1:0];
	assign front_y = front[2*C-1:C];

	assign adx_d = abs_diff(dest_x, pos_x_s1);
	assign ady_d = abs_diff(dest_y, pos_y_s1);
	assign adx_f = abs_diff(front_x, pos_x_s1);
	assign ady_f = abs_diff(front_y, pos_y_s1);

	assign sqx_d = SQW'(adx_d) * SQW'(adx_d);
	assign sqy_d = SQW'(ady_d) * SQW'(ady_d);
	assign sqx_f = SQW'(adx_f) * SQW'(adx_f);
	assign sqy_f = SQW'(ady_f) * SQW'(ady_f);
	assign sq_r  = SQW'(dest_r) * SQW'(dest_r);

	assign dist_d  = {1'b0, sqx_d} + {1'b0, sqy_d};
	assign reached = dest_valid_q && (dist_d < {1'b0, sq_r});

	assign is_step = action_s1 == ACT_STEP;
	// Move on to the queue front when the goal is reached or missing and the queue is not empty.
	assign take    = is_step && (reached || !dest_valid_q) && (count_q != '0);

	assign stx_d = unit_step(sqx_d, sqy_d, dest_x, pos_x_s1);
	assign sty_d = unit_step(sqy_d, sqx_d, dest_y, pos_y_s1);
	assign stx_f = unit_step(sqx_f, sqy_f, front_x, pos_x_s1);
	assign sty_f = unit_step(sqy_f, sqx_f, front_y, pos_y_s1);

	// ------------------------------------------------------------------
	// Next state
	// ------------------------------------------------------------------
	logic          do_add, overflow_n, push, pop;
	logic [EW-1:0] push_word;
	logic [CW-1:0] count_n, count_m1;
	logic          dest_valid_n;
	logic [C-1:0]  held_x_n, held_y_n;

	assign do_add     = !is_step && (count_q != CFULL);
	assign overflow_n = !is_step && (count_q == CFULL);
	assign pop        = adv_s2 && take;
	// An empty destination is never recycled into the queue.
	assign push       = adv_s2 && (do_add || (take && dest_valid_q));
	assign push_word  = is_step ? dest_q : {wp_r_s1, wp_y_s1, wp_x_s1};
	assign count_m1   = count_q - 1'b1;

	always_comb begin
		count_n = count_q;
		if (push && !pop)
			count_n = count_q + 1'b1;
		else if (pop && !push)
			count_n = count_m1;
	end

	always_comb begin
		dest_valid_n = dest_valid_q;
		held_x_n     = held_x_q;
		held_y_n     = held_y_q;
		if (is_step) begin
			if (take) begin
				dest_valid_n = 1'b1;
				held_x_n     = apply_step(pos_x_s1, stx_f);
				held_y_n     = apply_step(pos_y_s1, sty_f);
			end else if (dest_valid_q) begin
				held_x_n     = apply_step(pos_x_s1, stx_d);
				held_y_n     = apply_step(pos_y_s1, sty_d);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			dest_q       <= '0;
			dest_valid_q <= 1'b0;
			held_x_q     <= '0;
			held_y_q     <= '0;
		end else if (adv_s2) begin
			count_q      <= count_n;
			dest_valid_q <= dest_valid_n;
			held_x_q     <= held_x_n;
			held_y_q     <= held_y_n;
			if (take)
				dest_q <= front;
		end
	end

	// Queue storage: pop shifts toward entry 0, push writes just past the last entry.
	for (genvar i = 0; i < WAYPOINTS; i++) begin : g_fifo
		localparam logic [CW-1:0] IDX = CW'(i);
		if (i < WAYPOINTS - 1) begin : g_mid
			always_ff @(posedge clk) begin
				if (pop) begin
					fifo_q[i] <= (push && IDX == count_m1) ? push_word : fifo_q[i+1];
				end else if (push && IDX == count_q) begin
					fifo_q[i] <= push_word;
				end
			end
		end else begin : g_last
			always_ff @(posedge clk) begin
				if (pop) begin
					if (push && IDX == count_m1)
						fifo_q[i] <= push_word;
				end else if (push && IDX == count_q) begin
					fifo_q[i] <= push_word;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Result stage
	// ------------------------------------------------------------------
	logic         has_dest_s2, ovf_s2;
	logic [C-1:0] des_x_s2, des_y_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= 1'b1;
		end else if (result.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			has_dest_s2 <= dest_valid_n;
			des_x_s2    <= held_x_n;
			des_y_s2    <= held_y_n;
			ovf_s2      <= overflow_n;
		end
	end

	assign result.valid           = valid_s2;
	assign result.has_destination = has_dest_s2;
	assign result.desired_x       = des_x_s2;
	assign result.desired_y       = des_y_s2;
	assign result.overflow        = ovf_s2;

	// ------------------------------------------------------------------
	// Checks
	// ------------------------------------------------------------------
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CFULL)
		else $error("queue fill count beyond depth");

	a_dest_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		!$fell(dest_valid_q))
		else $error("destination lost after being set");

	a_step_no_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s2 && is_step) |=> !ovf_s2)
		else $error("overflow flagged on a step word");

	a_count_delta: assert property (@(posedge clk) disable iff (!arst_n)
		!adv_s2 |=> $stable(count_q))
		else $error("fill count moved without an advancing word");

	a_full_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s2 && !is_step && count_q == CFULL) |=> count_q == CFULL)
		else $error("add on a full queue changed the fill count");

endmodule

// ===== verif/tb_waypoint_seek_step_unit.sv =====
`timescale 1ns / 100ps

module tb_waypoint_seek_step_unit
	import wseek_pkg::*;
();

	localparam int WAYPOINTS   = 16;
	localparam int COORD_BITS  = 12;
	localparam int COORD_MAX   = (1 << COORD_BITS) - 1;
	localparam int STALL_LIMIT = 4000;  // cycles with no word moving on either side
	localparam int LONG_HOLD   = 64;    // result side hold-off, well past the two pipeline stages
	localparam int DRAIN_WAIT  = 8;     // covers the two pipeline stages plus margin

	// How a step picks its position once the word is about to go out.
	typedef enum int {
		AIM_NONE,    // position as generated
		AIM_INSIDE,  // within half the radius of the current destination: reached unless the radius is zero
		AIM_EDGE     // around the arrival circle: reached or not
	} aim_mode_t;

	typedef struct {
		logic                  act;
		logic [COORD_BITS-1:0] wp_x;
		logic [COORD_BITS-1:0] wp_y;
		logic [COORD_BITS-1:0] wp_radius;
		logic [COORD_BITS-1:0] pos_x;
		logic [COORD_BITS-1:0] pos_y;
		aim_mode_t             aim;
	} seek_word_t;

	typedef struct packed {
		logic [COORD_BITS-1:0] r;
		logic [COORD_BITS-1:0] y;
		logic [COORD_BITS-1:0] x;
	} waypoint_t;

	typedef struct {
		logic                  has_destination;
		logic [COORD_BITS-1:0] desired_x;
		logic [COORD_BITS-1:0] desired_y;
		logic                  overflow;
	} seek_result_t;

	logic clk;
	logic arst_n;

	wseek_item_if   #(.COORD_BITS(COORD_BITS)) item_bus ();
	wseek_result_if #(.COORD_BITS(COORD_BITS)) result_bus ();

	waypoint_seek_step_unit #(
		.WAYPOINTS  (WAYPOINTS),
		.COORD_BITS (COORD_BITS)
	) u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_bus),
		.result (result_bus)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// Words waiting for the driver, and results the block still owes us.
	seek_word_t   pending_words[$];
	seek_result_t expected_results[$];

	// Idling knobs, set by the sequencer between phases.
	int send_idle_pct = 27;
	int recv_idle_pct = 59;
	bit hold_go       = 1'b0;

	int fail_count  = 0;
	int idle_cycles = 0;

	// ------------------------------------------------------------------
	// Predictor state: waypoint ring, current destination, held position.
	// ------------------------------------------------------------------
	waypoint_t             wp_ring[WAYPOINTS];
	int                    wp_head    = 0;
	int                    wp_count   = 0;
	waypoint_t             goal       = '0;
	bit                    goal_valid = 1'b0;
	logic [COORD_BITS-1:0] steer_x    = '0;
	logic [COORD_BITS-1:0] steer_y    = '0;

	// Rounded unit step on one axis: sign(d) when 3d^2 >= e^2, else zero.
	function automatic int axis_step(int d, int e);
		if (3 * d * d >= e * e) begin
			if (d > 0)
				return 1;
			if (d < 0)
				return -1;
		end
		return 0;
	endfunction

	function automatic logic [COORD_BITS-1:0] clamp_coord(int v);
		if (v < 0)
			return '0;
		if (v > COORD_MAX)
			return COORD_MAX[COORD_BITS-1:0];
		return v[COORD_BITS-1:0];
	endfunction

	// Caller guarantees there is room.
	task automatic ring_append(input waypoint_t w);
		wp_ring[(wp_head + wp_count) % WAYPOINTS] = w;
		wp_count++;
	endtask

	// Advance the predictor by one accepted word and queue the result it owes.
	task automatic predict_seek(input logic act, input logic [COORD_BITS-1:0] wx, wy, wr,
			input logic [COORD_BITS-1:0] px, py);
		seek_result_t res;
		waypoint_t    next_goal;
		int           dx;
		int           dy;
		bit           reached;
		res.overflow = 1'b0;
		if (act == ACT_ADD) begin
			// Full ring drops the waypoint and flags it; nothing else moves.
			if (wp_count >= WAYPOINTS)
				res.overflow = 1'b1;
			else
				ring_append('{r: wr, y: wy, x: wx});
		end else begin
			reached = 1'b0;
			if (goal_valid) begin
				dx      = int'(goal.x) - int'(px);
				dy      = int'(goal.y) - int'(py);
				reached = (dx * dx + dy * dy) < (int'(goal.r) * int'(goal.r));
			end
			// Reached with an empty ring keeps the old destination.
			if ((reached || !goal_valid) && wp_count > 0) begin
				next_goal = wp_ring[wp_head];
				wp_head   = (wp_head + 1) % WAYPOINTS;
				wp_count--;
				// An empty destination is never recycled into the ring.
				if (goal_valid)
					ring_append(goal);
				goal       = next_goal;
				goal_valid = 1'b1;
			end
			// No destination at all: desired position is simply held.
			if (goal_valid) begin
				dx      = int'(goal.x) - int'(px);
				dy      = int'(goal.y) - int'(py);
				steer_x = clamp_coord(int'(px) + axis_step(dx, dy));
				steer_y = clamp_coord(int'(py) + axis_step(dy, dx));
			end
		end
		res.has_destination = goal_valid;
		res.desired_x       = steer_x;
		res.desired_y       = steer_y;
		expected_results.insert(expected_results.size(), res);
	endtask

	function automatic logic [COORD_BITS-1:0] near_coord(int c, int span);
		return clamp_coord(c + int'($urandom_range(0, 2 * span)) - span);
	endfunction

	// ------------------------------------------------------------------
	// Driver: predicts on acceptance, then offers the next pending word.
	// Prediction runs before the dequeue, so an aimed step sees the destination
	// exactly as it will stand when the step reaches the block.
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin : item_driver
		seek_word_t w;
		int         span;
		if (!arst_n) begin
			item_bus.valid     <= 1'b0;
			item_bus.action    <= ACT_ADD;
			item_bus.wp_x      <= '0;
			item_bus.wp_y      <= '0;
			item_bus.wp_radius <= '0;
			item_bus.pos_x     <= '0;
			item_bus.pos_y     <= '0;
		end else begin
			if (item_bus.valid && item_bus.ready)
				predict_seek(item_bus.action, item_bus.wp_x, item_bus.wp_y, item_bus.wp_radius,
					item_bus.pos_x, item_bus.pos_y);
			if (!item_bus.valid || item_bus.ready) begin
				if (pending_words.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					w = pending_words[0];
					pending_words.delete(0);
					if (w.act == ACT_STEP && w.aim != AIM_NONE && goal_valid) begin
						span    = (w.aim == AIM_INSIDE) ? int'(goal.r) / 2 : int'(goal.r) + 2;
						w.pos_x = near_coord(int'(goal.x), span);
						w.pos_y = near_coord(int'(goal.y), span);
					end
					item_bus.valid     <= 1'b1;
					item_bus.action    <= w.act;
					item_bus.wp_x      <= w.wp_x;
					item_bus.wp_y      <= w.wp_y;
					item_bus.wp_radius <= w.wp_radius;
					item_bus.pos_x     <= w.pos_x;
					item_bus.pos_y     <= w.pos_y;
				end else begin
					item_bus.valid <= 1'b0;
				end
			end
		end
	end

	task automatic check_field(input string label, input logic [COORD_BITS-1:0] want,
			input logic [COORD_BITS-1:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch: expected %0d, actual %0d", $time, label, want, got);
			fail_count++;
		end
	endtask

	// ------------------------------------------------------------------
	// Monitor: checks each result word against the oldest expectation and
	// throttles ready, with one long hold-off when the sequencer asks.
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin : result_monitor
		seek_result_t want;
		int           hold_left;
		bit           hold_done;
		if (!arst_n) begin
			result_bus.ready <= 1'b0;
			hold_left = 0;
			hold_done = 1'b0;
		end else begin
			if (result_bus.valid && result_bus.ready) begin
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result word: has_destination=%0b x=%0d y=%0d overflow=%0b",
						$time, result_bus.has_destination, result_bus.desired_x,
						result_bus.desired_y, result_bus.overflow);
					fail_count++;
				end else begin
					want = expected_results[0];
					expected_results.delete(0);
					check_field("has_destination", COORD_BITS'(want.has_destination),
						COORD_BITS'(result_bus.has_destination));
					check_field("desired_x", want.desired_x, result_bus.desired_x);
					check_field("desired_y", want.desired_y, result_bus.desired_y);
					check_field("overflow", COORD_BITS'(want.overflow),
						COORD_BITS'(result_bus.overflow));
				end
			end
			if (hold_go && !hold_done) begin
				hold_done = 1'b1;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_bus.ready <= 1'b0;
			end else begin
				result_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
			end
		end
	end

	// Watchdog: a hung handshake on either side ends the run.
	always @(posedge clk) begin
		if (!arst_n || (item_bus.valid && item_bus.ready) || (result_bus.valid && result_bus.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus builders
	// ------------------------------------------------------------------
	function automatic int any_coord();
		return int'($urandom_range(0, COORD_MAX));
	endfunction

	task automatic queue_add(input int x, y, r);
		seek_word_t w;
		w.act       = ACT_ADD;
		w.wp_x      = x[COORD_BITS-1:0];
		w.wp_y      = y[COORD_BITS-1:0];
		w.wp_radius = r[COORD_BITS-1:0];
		w.pos_x     = COORD_BITS'(any_coord());  // ignored by an add
		w.pos_y     = COORD_BITS'(any_coord());
		w.aim       = AIM_NONE;
		pending_words.insert(pending_words.size(), w);
	endtask

	task automatic queue_step(input int x, y, input aim_mode_t aim);
		seek_word_t w;
		w.act       = ACT_STEP;
		w.wp_x      = COORD_BITS'(any_coord());  // ignored by a step
		w.wp_y      = COORD_BITS'(any_coord());
		w.wp_radius = COORD_BITS'(any_coord());
		w.pos_x     = x[COORD_BITS-1:0];
		w.pos_y     = y[COORD_BITS-1:0];
		w.aim       = aim;
		pending_words.insert(pending_words.size(), w);
	endtask

	// Zero radius can never be reached, so it would pin the destination for
	// good; it only shows up near the end of the run.
	function automatic int pick_radius(bit allow_zero);
		int sel;
		sel = $urandom_range(0, 9);
		if (allow_zero && sel == 0)
			return 0;
		if (sel == 1)
			return COORD_MAX;
		if (sel == 2)
			return $urandom_range(1, COORD_MAX);
		if (sel <= 4)
			return $urandom_range(1, 4);
		return $urandom_range(5, 600);
	endfunction

	// Mostly steps aimed at the live destination so the ring keeps turning;
	// the rest are adds, occasional bursts that overrun the ring, and steps
	// from anywhere.
	task automatic queue_random(input int n, input bit allow_zero);
		int roll;
		repeat (n) begin
			roll = $urandom_range(0, 99);
			if (roll < 2) begin
				repeat (WAYPOINTS + 2)
					queue_add(any_coord(), any_coord(), pick_radius(allow_zero));
			end else if (roll < 22) begin
				queue_add(any_coord(), any_coord(), pick_radius(allow_zero));
			end else if (roll < 62) begin
				queue_step(any_coord(), any_coord(), AIM_INSIDE);
			end else if (roll < 87) begin
				queue_step(any_coord(), any_coord(), AIM_EDGE);
			end else begin
				queue_step(any_coord(), any_coord(), AIM_NONE);
			end
		end
	endtask

	task automatic wait_sent();
		while (pending_words.size() != 0)
			@(negedge clk);
	endtask

	// ------------------------------------------------------------------
	// Sequencer
	// ------------------------------------------------------------------
	initial begin : sequencer
		int i;
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: no destination and empty ring, position held at both extremes.
		queue_step(0, 0, AIM_NONE);
		queue_step(COORD_MAX, COORD_MAX, AIM_NONE);
		// First destination taken from the ring; zero difference gives a zero step.
		queue_add(100, 200, 1);
		queue_step(100, 200, AIM_NONE);
		// Reached again with an empty ring: destination kept.
		queue_step(100, 200, AIM_NONE);
		queue_add(COORD_MAX, COORD_MAX, COORD_MAX);
		queue_add(0, 0, COORD_MAX);
		// Far off on x, y too small to step.
		queue_step(COORD_MAX, 0, AIM_NONE);
		// Reached: front becomes destination, old one goes to the back.
		queue_step(100, 200, AIM_NONE);
		queue_step(COORD_MAX - 1, COORD_MAX - 1, AIM_NONE);
		// Fill the ring to capacity with extreme values, then overrun it twice.
		for (i = 0; i < WAYPOINTS - 2; i++) begin
			case (i % 3)
				0: queue_add(COORD_MAX, 0, COORD_MAX);
				1: queue_add(0, COORD_MAX, $urandom_range(1, COORD_MAX));
				default: queue_add(any_coord(), any_coord(), pick_radius(1'b0));
			endcase
		end
		queue_add(any_coord(), any_coord(), pick_radius(1'b0));
		queue_add(COORD_MAX, COORD_MAX, COORD_MAX);
		queue_step(0, 0, AIM_NONE);
		wait_sent();

		// Random, sender idles lightly, receiver heavily.
		queue_random(210, 1'b0);
		wait_sent();

		// Swap the idling.
		send_idle_pct = 59;
		recv_idle_pct = 27;
		queue_random(210, 1'b0);
		wait_sent();

		// No idling; one long receiver hold-off backs the pipe up into the input.
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_go       = 1'b1;
		queue_random(170, 1'b0);
		queue_random(30, 1'b1);
		wait_sent();

		while (item_bus.valid || expected_results.size() != 0)
			@(negedge clk);
		repeat (DRAIN_WAIT) @(negedge clk);

		if (fail_count == 0 && expected_results.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
